>>> src/mbrot_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel engine package
// Shared types, register indexes, reset values and default parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrot_pkg;

  localparam int COORD_W   = 12;
  localparam int CFG_W     = 32;
  localparam int COUNT_W   = 16;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_BITS_DEF        = 28;
  localparam int PIXEL_COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH          = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 2'd3;

  // Reset values: -2.3, -1.0 and 0.002 in Q4.28, limit of 1024*4.
  localparam logic signed [31:0] ORIGIN_REAL_RST = -32'sd617401549;
  localparam logic signed [31:0] ORIGIN_IMAG_RST = -32'sd268435456;
  localparam logic signed [31:0] PIXEL_STEP_RST  = 32'sd536871;
  localparam logic [COUNT_W-1:0] MAX_ITER_RST    = 16'd4096;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] escape_count;
    logic [COLOR_W-1:0] pixel_color;
  } result_t;

  // A point c of the complex plane, both parts saturated to 32 bits.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } point_t;

endpackage

`default_nettype wire

>>> src/mbrot_front.sv
// ----------------------------------------------------------------------------
// Mandelbrot front end
// Accepts pixel items and maps them to saturated points of the plane.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrot_front #(
  parameter int PIXEL_COORD_BITS = mbrot_pkg::PIXEL_COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pixel_valid,
  output logic                    pixel_stall,
  input  wire mbrot_pkg::pixel_t  pixel,
  input  wire logic signed [31:0] origin_real,
  input  wire logic signed [31:0] origin_imag,
  input  wire logic signed [31:0] pixel_step,
  output logic                    push_valid,
  input  wire logic               push_stall,
  output mbrot_pkg::point_t       push_point
);

  localparam int CW = PIXEL_COORD_BITS;
  localparam int PW = CW + 34;
  localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sh7FFF_FFFF);
  localparam logic signed [PW-1:0] SAT_MIN = -PW'(64'sh8000_0000);

  logic          held;
  logic [CW-1:0] col_q;
  logic [CW-1:0] row_q;

  logic signed [CW+32:0] prod_x;
  logic signed [CW+32:0] prod_y;
  logic signed [PW-1:0]  sum_x;
  logic signed [PW-1:0]  sum_y;

  assign pixel_stall = held && push_stall;
  assign push_valid  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (pixel_valid && !pixel_stall) begin
      held <= 1'b1;
    end else if (held && !push_stall) begin
      held <= 1'b0;
    end
  end

  // Coordinates are taken in their low PIXEL_COORD_BITS bits.
  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      col_q <= CW'(pixel.column);
      row_q <= CW'(pixel.row);
    end
  end

  assign prod_x = $signed({1'b0, col_q}) * pixel_step;
  assign prod_y = $signed({1'b0, row_q}) * pixel_step;
  assign sum_x  = PW'(prod_x) + PW'(origin_real);
  assign sum_y  = PW'(prod_y) + PW'(origin_imag);

  always_comb begin
    if (sum_x > SAT_MAX) begin
      push_point.cx = 32'sh7FFF_FFFF;
    end else if (sum_x < SAT_MIN) begin
      push_point.cx = 32'sh8000_0000;
    end else begin
      push_point.cx = sum_x[31:0];
    end
    if (sum_y > SAT_MAX) begin
      push_point.cy = 32'sh7FFF_FFFF;
    end else if (sum_y < SAT_MIN) begin
      push_point.cy = 32'sh8000_0000;
    end else begin
      push_point.cy = sum_y[31:0];
    end
  end

endmodule

`default_nettype wire

>>> src/mbrot_queue.sv
// ----------------------------------------------------------------------------
// Mandelbrot point queue
// Short first-in first-out queue between the front end and the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrot_queue #(
  parameter int DEPTH = mbrot_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  output logic                   wr_stall,
  input  wire mbrot_pkg::point_t wr_point,
  output logic                   rd_valid,
  input  wire logic              rd_stall,
  output mbrot_pkg::point_t      rd_point
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  mbrot_pkg::point_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign wr_stall = (fill == NW'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_point = entries[rd_ptr];
  assign do_wr    = wr_valid && !wr_stall;
  assign do_rd    = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/mbrot_core.sv
// ----------------------------------------------------------------------------
// Mandelbrot iteration core
// Runs z = z^2 + c, one complex step per cycle, and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrot_core #(
  parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [mbrot_pkg::COUNT_W-1:0]   max_iterations,
  input  wire logic                            pop_valid,
  output logic                                 pop_stall,
  input  wire mbrot_pkg::point_t               pop_point,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output mbrot_pkg::result_t                   result
);

  // z never grows beyond 2^(F+2) plus a 32-bit c, so ZW bits never wrap.
  localparam int ZW = ((FRAC_BITS + 3 > 32) ? FRAC_BITS + 3 : 32) + 2;
  localparam int MW = FRAC_BITS + 2;
  localparam int SW = 2 * MW + 1;
  localparam logic [ZW-1:0] BOUND = ZW'(1) << (FRAC_BITS + 1);
  localparam logic [SW-1:0] FOUR  = SW'(1) << (2 * FRAC_BITS + 2);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } core_state_t;

  core_state_t                   state;
  logic signed [31:0]            cx;
  logic signed [31:0]            cy;
  logic signed [ZW-1:0]          x;
  logic signed [ZW-1:0]          y;
  logic [mbrot_pkg::COUNT_W-1:0] n;

  logic [ZW-1:0]        ax;
  logic [ZW-1:0]        ay;
  logic                 big;
  logic [2*MW-1:0]      xx;
  logic [2*MW-1:0]      yy;
  logic [2*MW-1:0]      xy;
  logic [SW-1:0]        mag2;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] prod;
  logic signed [SW-1:0] diff_sh;
  logic signed [SW-1:0] prod_sh;
  logic signed [ZW-1:0] x_next;
  logic signed [ZW-1:0] y_next;
  logic                 at_limit;
  logic                 escaped;
  logic                 finish;
  logic                 out_free;
  logic [mbrot_pkg::COUNT_W-1:0] count;

  assign ax  = x[ZW-1] ? ZW'(-x) : ZW'(x);
  assign ay  = y[ZW-1] ? ZW'(-y) : ZW'(y);
  assign big = (ax > BOUND) || (ay > BOUND);

  assign xx   = ax[MW-1:0] * ax[MW-1:0];
  assign yy   = ay[MW-1:0] * ay[MW-1:0];
  assign xy   = ax[MW-1:0] * ay[MW-1:0];
  assign mag2 = SW'(xx) + SW'(yy);

  // Arithmetic right shifts round toward minus infinity.
  assign diff    = $signed({1'b0, xx}) - $signed({1'b0, yy});
  assign prod    = (x[ZW-1] != y[ZW-1]) ? -$signed({1'b0, xy}) : $signed({1'b0, xy});
  assign diff_sh = diff >>> FRAC_BITS;
  assign prod_sh = prod >>> (FRAC_BITS - 1);
  assign x_next  = ZW'(diff_sh) + ZW'(cx);
  assign y_next  = ZW'(prod_sh) + ZW'(cy);

  assign at_limit = (n == max_iterations);
  assign escaped  = big || (mag2 > FOUR);
  assign finish   = (state == ST_RUN) && (at_limit || escaped);
  assign out_free = !result_valid || !result_stall;
  assign count    = at_limit ? '0 : n;
  assign pop_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (finish && out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cx <= pop_point.cx;
      cy <= pop_point.cy;
      x  <= ZW'(pop_point.cx);
      y  <= ZW'(pop_point.cy);
      n  <= '0;
    end else if (!finish) begin
      x <= x_next;
      y <= y_next;
      n <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Color word is count*10, formed as count*8 + count*2.
  always_ff @(posedge clk) begin
    if (finish && out_free) begin
      result.escape_count <= count;
      result.pixel_color  <= (mbrot_pkg::COLOR_W'(count) << 3)
                           + (mbrot_pkg::COLOR_W'(count) << 1);
    end
  end

endmodule

`default_nettype wire

>>> src/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel engine
// Maps a pixel to a point c and counts z = z^2 + c updates until escape.
// ----------------------------------------------------------------------------
// Each pixel item becomes c = origin + position*pixel_step (signed, FRAC_BITS
// fraction bits, each part saturated to 32 bits), then z starts at c and is
// updated while |z|^2 <= 4, at most max_iterations times. The result item
// carries the update count, or 0 when the limit is reached, and a color word
// equal to ten times the count. The iteration core does one complex update
// per cycle. A pixel item passes the front stage and the queue, is loaded
// into the core while it is idle, is updated until it escapes or reaches
// the limit, and its result item is then registered at the output. The core
// works on one item at a time. Until they fill, the front end and a two-entry
// queue take items while the core is busy, and a finished result waits in the
// output register without blocking new input. Configuration registers are
// written through a simple write port and should only change while the
// engine is idle; the reset values frame the classic view near -2.3 - 1.0i.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS        = mbrot_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_COORD_BITS = mbrot_pkg::PIXEL_COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [mbrot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbrot_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                              pixel_valid,
  output logic                                   pixel_stall,
  input  wire mbrot_pkg::pixel_t                 pixel,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output mbrot_pkg::result_t                     result
);

  logic signed [31:0]            origin_real;
  logic signed [31:0]            origin_imag;
  logic signed [31:0]            pixel_step;
  logic [mbrot_pkg::COUNT_W-1:0] max_iterations;

  logic              push_valid;
  logic              push_stall;
  mbrot_pkg::point_t push_point;
  logic              pop_valid;
  logic              pop_stall;
  mbrot_pkg::point_t pop_point;

  // Configuration registers. Writes to an index outside the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real    <= mbrot_pkg::ORIGIN_REAL_RST;
      origin_imag    <= mbrot_pkg::ORIGIN_IMAG_RST;
      pixel_step     <= mbrot_pkg::PIXEL_STEP_RST;
      max_iterations <= mbrot_pkg::MAX_ITER_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        mbrot_pkg::REG_ORIGIN_REAL: origin_real    <= cfg_data[31:0];
        mbrot_pkg::REG_ORIGIN_IMAG: origin_imag    <= cfg_data[31:0];
        mbrot_pkg::REG_PIXEL_STEP:  pixel_step     <= cfg_data[31:0];
        mbrot_pkg::REG_MAX_ITER:    max_iterations <= cfg_data[mbrot_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end registers the coordinates and forms the point c.
  mbrot_front #(
    .PIXEL_COORD_BITS(PIXEL_COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .origin_real (origin_real),
    .origin_imag (origin_imag),
    .pixel_step  (pixel_step),
    .push_valid  (push_valid),
    .push_stall  (push_stall),
    .push_point  (push_point)
  );

  // The queue decouples the front end from the long-running core.
  mbrot_queue #(
    .DEPTH(mbrot_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_stall (push_stall),
    .wr_point (push_point),
    .rd_valid (pop_valid),
    .rd_stall (pop_stall),
    .rd_point (pop_point)
  );

  // The core iterates one point and presents its result item.
  mbrot_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .pop_valid      (pop_valid),
    .pop_stall      (pop_stall),
    .pop_point      (pop_point),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule

`default_nettype wire

>>> src/mbrot_checker.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel engine checker
// Port-level assertions on the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrot_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            pixel_valid,
  input wire logic                            pixel_stall,
  input wire logic                            result_valid,
  input wire logic                            result_stall,
  input wire mbrot_pkg::result_t              result
);

  // Front stage, queue entries, core and result register.
  localparam logic [3:0] CAPACITY = 4'(mbrot_pkg::QUEUE_DEPTH + 3);

  logic [3:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = pixel_valid && !pixel_stall;
  assign out_acc = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result item changed");

  a_color: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.pixel_color ==
      (mbrot_pkg::COLOR_W'(result.escape_count) * mbrot_pkg::COLOR_W'(10)))
    else $error("color word does not match escape count");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result item shown right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != '0)
    else $error("result item without an accepted pixel item");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= CAPACITY)
    else $error("more pixel items in flight than the engine can hold");

endmodule

bind mandelbrot_escape_time_pixel mbrot_checker u_checker (.*);

`default_nettype wire

>>> dv/mandelbrot_escape_time_pixel_test.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel engine testbench
// Streams pixel items through the engine under several plane views and
// compares every result item with a cycle-free model of the escape count.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = mbrot_pkg::FRAC_BITS_DEF;

  // A point escapes once either part of z passes 2; the squared test
  // compares against 4 held with twice the fraction bits.
  localparam longint ESC_BOUND = 64'sd1 <<< (FRAC + 1);
  localparam longint FOUR_SQ   = 64'sd1 <<< (2 * FRAC + 2);

  // The slowest pixel needs 65535 updates in the core on top of queueing
  // and output, and the receiver can hold its result back longer. The limit
  // covers that several times over.
  localparam int STUCK_LIMIT = 300000;

  logic clk;
  logic rst;

  logic                            cfg_wen     = 1'b0;
  logic [mbrot_pkg::CFG_IDX_W-1:0] cfg_index   = mbrot_pkg::REG_ORIGIN_REAL;
  logic [mbrot_pkg::CFG_W-1:0]     cfg_data    = '0;
  logic                            pixel_valid = 1'b0;
  logic                            pixel_stall;
  mbrot_pkg::pixel_t               pixel       = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  mbrot_pkg::result_t              result;

  // Our own copy of the view registers, starting from the reset values.
  logic signed [31:0] view_re    = mbrot_pkg::ORIGIN_REAL_RST;
  logic signed [31:0] view_im    = mbrot_pkg::ORIGIN_IMAG_RST;
  logic signed [31:0] view_step  = mbrot_pkg::PIXEL_STEP_RST;
  logic [15:0]        iter_limit = mbrot_pkg::MAX_ITER_RST;

  mbrot_pkg::pixel_t  pixel_queue[$];
  mbrot_pkg::result_t expected_results[$];
  mbrot_pkg::result_t oldest_expected;
  mbrot_pkg::pixel_t  next_pixel;

  int error_count      = 0;
  int results_checked  = 0;
  int settings_applied = 0;
  int stuck_cycles     = 0;

  // Sender burst state and receiver stall pattern state.
  int burst_left     = 1;
  int gap_left       = 0;
  int stall_mode     = 0;
  int stall_mode_len = 0;
  int stall_phase    = 0;

  mandelbrot_escape_time_pixel i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Escape-count model
  // --------------------------------------------------------------------------

  function automatic longint clamp_q428(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Maps the pixel to c with the current view, then iterates z = z^2 + c.
  // Once the bound test has passed, both parts of z are at most 2 in
  // magnitude, so every square and product below fits in 64 bits. The
  // arithmetic shift rounds toward minus infinity, as the engine does.
  function automatic mbrot_pkg::result_t predict_escape(input mbrot_pkg::pixel_t px);
    longint             cx, cy, x, y, ax, ay, xx, yy, nx;
    int unsigned        n;
    int unsigned        count;
    mbrot_pkg::result_t r;
    cx = clamp_q428(longint'(view_re) + longint'(px.column) * longint'(view_step));
    cy = clamp_q428(longint'(view_im) + longint'(px.row) * longint'(view_step));
    x = cx;
    y = cy;
    for (n = 0; n < iter_limit; n++) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ax > ESC_BOUND || ay > ESC_BOUND) break;
      xx = ax * ax;
      yy = ay * ay;
      if (xx + yy > FOUR_SQ) break;
      nx = ((xx - yy) >>> FRAC) + cx;
      y  = ((x * y) >>> (FRAC - 1)) + cy;
      x  = nx;
    end
    // Reaching the limit means the point counts as inside the set.
    count = (n == iter_limit) ? 0 : n;
    r.escape_count = count[mbrot_pkg::COUNT_W-1:0];
    r.pixel_color  = mbrot_pkg::COLOR_W'(count * 10);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Pixel driver: bursts of items with random gaps in between. A held item
  // stays on the bus unchanged until the engine takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || !pixel_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        pixel_valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        next_pixel = pixel_queue.pop_front();
        pixel       <= next_pixel;
        pixel_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          // A quarter of the bursts run straight into the next one.
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: switches between no stalls, coin-flip stalls and long
  // regular stall windows, each mode lasting a random stretch of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_mode_len == 0) begin
        stall_mode     = $urandom_range(0, 2);
        stall_mode_len = $urandom_range(20, 200);
        stall_phase    = 0;
      end
      stall_mode_len--;
      stall_phase++;
      case (stall_mode)
        0: begin
          result_stall <= 1'b0;
        end
        1: begin
          result_stall <= 1'($urandom_range(0, 1));
        end
        default: begin
          result_stall <= ((stall_phase % 16) < 11);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted pixel adds its predicted result to the store,
  // and every accepted result is checked against the oldest prediction.
  // The engine keeps items in order, so a plain queue is enough.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        expected_results.push_back(predict_escape(pixel));
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result item count=%0d with no pixel waiting",
                                    result.escape_count));
        end else begin
          oldest_expected = expected_results.pop_front();
          results_checked++;
          if (result.escape_count !== oldest_expected.escape_count) begin
            report_mismatch($sformatf("escape_count got %0d expected %0d",
                                      result.escape_count, oldest_expected.escape_count));
          end
          if (result.pixel_color !== oldest_expected.pixel_color) begin
            report_mismatch($sformatf("pixel_color got 0x%06h expected 0x%06h",
                                      result.pixel_color, oldest_expected.pixel_color));
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which work is pending but no item moves on
  // either channel.
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (!pixel_valid && expected_results.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
               stuck_cycles, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_pixel(input int col, input int row);
    mbrot_pkg::pixel_t p;
    p.column = col[mbrot_pkg::COORD_W-1:0];
    p.row    = row[mbrot_pkg::COORD_W-1:0];
    pixel_queue.push_back(p);
  endtask

  // Holds until every queued pixel has been taken and every result has come
  // back. Each pixel yields exactly one result, so the engine is idle then.
  task automatic wait_for_drain();
    @(posedge clk);
    while (pixel_queue.size() != 0 || pixel_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One write per clock edge; cfg_wen stays high across back-to-back writes.
  task automatic write_reg(input logic [mbrot_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mbrot_pkg::CFG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mbrot_pkg::REG_ORIGIN_REAL: view_re    = val;
      mbrot_pkg::REG_ORIGIN_IMAG: view_im    = val;
      mbrot_pkg::REG_PIXEL_STEP:  view_step  = val;
      default:                    iter_limit = val[15:0];
    endcase
    @(posedge clk);
  endtask

  // Changes the whole view once the engine has gone idle.
  task automatic apply_view(input logic [31:0] re, input logic [31:0] im,
                            input logic [31:0] step, input logic [15:0] limit);
    wait_for_drain();
    write_reg(mbrot_pkg::REG_ORIGIN_REAL, re);
    write_reg(mbrot_pkg::REG_ORIGIN_IMAG, im);
    write_reg(mbrot_pkg::REG_PIXEL_STEP, step);
    write_reg(mbrot_pkg::REG_MAX_ITER, {16'd0, limit});
    cfg_wen <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int phase;
    int k;
    int re;
    int im;
    int st;
    int step_max;

    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset view: frame corners, alternating bit patterns, and one pixel
    // that lands on the origin of the plane and runs the full 4096 updates.
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(1150, 500);
    queue_pixel(2048, 2048);
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    queue_pixel(1, 1);

    // Saturating views: extreme origins and steps push at least one part of c to
    // an end of the 32-bit range, so z starts far outside the escape radius.
    apply_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd65535);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    apply_view(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 16'd65535);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);

    // c = -2 exactly sits on the escape circle: |z|^2 stays equal to 4 and
    // never exceeds it, so the point lasts the largest limit.
    apply_view(-32'sd536870912, 32'h0000_0000, 32'h0000_0000, 16'd65535);
    queue_pixel(77, 3000);

    // A zero limit runs no update at all.
    apply_view(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 16'd0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);

    // A limit of one: a single update, then the point counts as inside.
    apply_view(-32'sd268435456, -32'sd134217728, 32'h0004_0000, 16'd1);
    queue_pixel(0, 0);
    queue_pixel(3000, 100);

    // Random views around the set, with steps that grow phase by phase so
    // the early ones zoom in where points survive many updates.
    for (phase = 0; phase < 7; phase++) begin
      if (phase == 3) begin
        // Fully random registers, which saturate c for most pixels.
        apply_view($urandom, $urandom, $urandom, 16'($urandom_range(1, 64)));
      end else begin
        re       = int'($urandom_range(0, 805306368)) - 671088640;
        im       = int'($urandom_range(0, 805306368)) - 402653184;
        step_max = 1 << (12 + phase);
        st       = int'($urandom_range(1, step_max));
        if ($urandom_range(0, 1) == 1) st = -st;
        apply_view(re, im, st, 16'($urandom_range(1, (phase == 6) ? 2000 : 300)));
      end
      for (k = 0; k < 18; k++) begin
        // Half the pixels stay near the top-left corner, where a zoomed
        // view keeps them close to the set.
        if ($urandom_range(0, 1) == 1) begin
          queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        end else begin
          queue_pixel($urandom_range(0, 511), $urandom_range(0, 511));
        end
        // Midway through one phase the sender holds off until the engine
        // has returned everything it owes.
        if (phase == 2 && k == 9) wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (16) @(posedge clk);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("Checked %0d result items over %0d register views after the reset view,",
             results_checked, settings_applied);
    $display("covering saturated c, the escape boundary, zero and full limits, random zooms.");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
